// ===== rtl/afp_pkg.sv =====
// ----------------------------------------------------------------------------
// afp_pkg
// Types and constants shared by the attitude frame parser modules.
// ----------------------------------------------------------------------------
package afp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] KIND_BYTE = 8'h01;

    localparam logic [6:0] MAX_LENGTH_RESET    = 7'd60;
    localparam logic [6:0] TRAILER_EXTRA_RESET = 7'd8;

    // Register select is paddr[2]
    localparam logic REG_MAX_LENGTH    = 1'b0;
    localparam logic REG_TRAILER_EXTRA = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int ATT_BYTES = 6;
    localparam int ATT_IW    = $clog2(ATT_BYTES);
    localparam logic [7:0] ATT_FIRST_POS = 8'd4;
    localparam logic [7:0] ATT_END_POS   = 8'd10;

    localparam int OUT_TDATA_W = 56;

    typedef enum logic [2:0] {
        HUNT_IDLE,
        HUNT_SYNC1,
        HUNT_SYNC2,
        HUNT_LEN,
        HUNT_BODY,
        HUNT_FINAL
    } hunt_state_t;

    typedef enum logic [1:0] {
        OP_START,   // data is the accepted length byte
        OP_BODY,    // data is a body byte
        OP_LAST     // data is the final byte of the frame
    } afp_op_t;

    typedef struct packed {
        afp_op_t    op;
        logic [7:0] data;
    } afp_entry_t;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_CW-1:0] count;
    } afp_q_status_t;

endpackage

// ===== rtl/attitude_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// attitude_frame_parser_core
// Byte-serial attitude frame parser: header hunt, checksum and angle decode.
//
//   Channel   Dir   Contents
//   s_*       in    one received byte per transaction
//   m_*       out   one result per complete frame
//   APB       in    max_length (0x0), trailer_extra (0x4)
//
// One byte per cycle is accepted while the 4-entry command queue has room.
// The decoder retires one command per cycle; a result sits in the output
// register and stalls only final-byte commands while it is not taken.
// m_tvalid rises once the final byte has passed the command queue and the output register.
// aresetn is synchronous; it clears hunt state, queue and output valid.
// ----------------------------------------------------------------------------
module attitude_frame_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] rx_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // m_tdata: [0] checksum_ok, [16:1] roll, [32:17] pitch, [48:33] yaw
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [afp_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import afp_pkg::*;

    logic [6:0]     max_length_reg, max_length_next;
    logic [6:0]     trailer_extra_reg, trailer_extra_next;
    logic           cfg_write;
    logic           push, pop;
    afp_entry_t     push_entry, head;
    afp_q_status_t  q_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        max_length_next    = max_length_reg;
        trailer_extra_next = trailer_extra_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_MAX_LENGTH:    max_length_next    = pwdata[6:0];
                REG_TRAILER_EXTRA: trailer_extra_next = pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MAX_LENGTH:    prdata = {25'd0, max_length_reg};
            REG_TRAILER_EXTRA: prdata = {25'd0, trailer_extra_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg    <= MAX_LENGTH_RESET;
            trailer_extra_reg <= TRAILER_EXTRA_RESET;
        end else begin
            max_length_reg    <= max_length_next;
            trailer_extra_reg <= trailer_extra_next;
        end
    end

    afp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .max_length    (max_length_reg),
        .trailer_extra (trailer_extra_reg),
        .q_full        (q_status.full),
        .push          (push),
        .push_entry    (push_entry)
    );

    afp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    afp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_status.empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A new result only comes from retiring a final-byte command
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pop && head.op == OP_LAST))
        else $error("result appeared without a final byte");

    // Queue occupancy stays within its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

    // Nothing is left in flight when reset is released
    a_reset_clean: assert property (@(posedge aclk)
        $rose(aresetn) |-> (q_status.empty && !m_tvalid))
        else $error("state survived reset");

endmodule

// ===== rtl/afp_front.sv =====
// ----------------------------------------------------------------------------
// afp_front
// Header hunter: tracks the sync pattern and body count, and queues one
// command for the length byte and for each later byte of a frame.
// ----------------------------------------------------------------------------
module afp_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic [6:0]            max_length,
    input  logic [6:0]            trailer_extra,
    input  logic                  q_full,
    output logic                  push,
    output afp_pkg::afp_entry_t   push_entry
);
    import afp_pkg::*;

    hunt_state_t state_reg, state_next;
    logic [7:0]  remain_reg, remain_next;
    logic        accept;
    logic [7:0]  remain_dec;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign remain_dec = remain_reg - 8'd1;

    always_comb begin
        state_next      = state_reg;
        remain_next     = remain_reg;
        push            = 1'b0;
        push_entry.op   = OP_BODY;
        push_entry.data = s_tdata;
        if (accept) begin
            case (state_reg)
                HUNT_IDLE: begin
                    if (s_tdata == SYNC_BYTE) state_next = HUNT_SYNC1;
                end
                HUNT_SYNC1: begin
                    state_next = (s_tdata == SYNC_BYTE) ? HUNT_SYNC2 : HUNT_IDLE;
                end
                HUNT_SYNC2: begin
                    state_next = (s_tdata == KIND_BYTE) ? HUNT_LEN : HUNT_IDLE;
                end
                HUNT_LEN: begin
                    if (s_tdata < {1'b0, max_length}) begin
                        state_next    = HUNT_BODY;
                        remain_next   = {1'b0, s_tdata[6:0]} + {1'b0, trailer_extra};
                        push          = 1'b1;
                        push_entry.op = OP_START;
                    end else begin
                        state_next = HUNT_IDLE;
                    end
                end
                HUNT_BODY: begin
                    // empty body: this byte breaks the pattern
                    if (remain_reg != 8'd0) begin
                        push        = 1'b1;
                        remain_next = remain_dec;
                        if (remain_dec == 8'd0) state_next = HUNT_FINAL;
                    end else begin
                        state_next = HUNT_IDLE;
                    end
                end
                HUNT_FINAL: begin
                    push          = 1'b1;
                    push_entry.op = OP_LAST;
                    state_next    = HUNT_IDLE;
                end
                default: begin
                    state_next = HUNT_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= HUNT_IDLE;
            remain_reg <= 8'd0;
        end else begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ===== rtl/afp_queue.sv =====
// ----------------------------------------------------------------------------
// afp_queue
// Small first-word-fall-through queue between the hunter and the decoder.
// ----------------------------------------------------------------------------
module afp_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  afp_pkg::afp_entry_t    push_entry,
    input  logic                   pop,
    output afp_pkg::afp_entry_t    head,
    output afp_pkg::afp_q_status_t status
);
    import afp_pkg::*;

    afp_entry_t          queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;
    assign head         = queue_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push) queue_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/afp_back.sv =====
// ----------------------------------------------------------------------------
// afp_back
// Frame decoder: running checksum, check byte capture, attitude bytes and
// the result register.
// ----------------------------------------------------------------------------
module afp_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  afp_pkg::afp_entry_t          head,
    input  logic                         q_empty,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [afp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import afp_pkg::*;

    logic [7:0] pos_reg, pos_next;
    logic [6:0] len_reg, len_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] check_reg, check_next;
    logic [7:0] att_reg [ATT_BYTES];
    logic [7:0] att_next [ATT_BYTES];
    logic       out_valid_reg, out_valid_next;
    logic       ok_reg, ok_next;
    logic [15:0] roll_reg, pitch_reg, yaw_reg;
    logic [15:0] roll_next, pitch_next, yaw_next;

    logic [7:0]        v;
    logic [8:0]        pos_inc;
    logic [7:0]        att_off;
    logic [ATT_IW-1:0] att_idx;
    logic [7:0]        start_sum;
    logic [7:0]        start_check;

    assign v       = head.data;
    assign pos_inc = {1'b0, pos_reg} + 9'd1;
    assign att_off = pos_reg - ATT_FIRST_POS;
    assign att_idx = att_off[ATT_IW-1:0];

    // Only the final byte needs the result register
    assign pop = !q_empty && (head.op != OP_LAST || !out_valid_reg || m_tready);

    // Header bytes and length byte at positions 0..3 folded into one step
    always_comb begin
        start_sum = 8'd0;
        if (v[6:0] > 7'd1) start_sum = start_sum + SYNC_BYTE;
        if (v[6:0] > 7'd2) start_sum = start_sum + SYNC_BYTE;
        if (v[6:0] > 7'd3) start_sum = start_sum + KIND_BYTE;
        if (v[6:0] > 7'd4) start_sum = start_sum + v;
        case (v[6:0])
            7'd1:    start_check = SYNC_BYTE;
            7'd2:    start_check = SYNC_BYTE;
            7'd3:    start_check = KIND_BYTE;
            7'd4:    start_check = v;
            default: start_check = 8'd0;
        endcase
    end

    always_comb begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        check_next = check_reg;
        for (int i = 0; i < ATT_BYTES; i++) att_next[i] = att_reg[i];
        if (pop) begin
            if (head.op == OP_START) begin
                len_next   = v[6:0];
                pos_next   = ATT_FIRST_POS;
                sum_next   = start_sum;
                check_next = start_check;
                for (int i = 0; i < ATT_BYTES; i++) att_next[i] = 8'd0;
            end else begin
                if (len_reg != 7'd0) begin
                    if (pos_inc < {2'b00, len_reg}) sum_next = sum_reg + v;
                    else if (pos_inc == {2'b00, len_reg}) check_next = v;
                end
                if (pos_reg >= ATT_FIRST_POS && pos_reg < ATT_END_POS)
                    att_next[att_idx] = v;
                if (pos_reg != 8'hFF) pos_next = pos_inc[7:0];
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        roll_next      = roll_reg;
        pitch_next     = pitch_reg;
        yaw_next       = yaw_reg;
        if (m_tready) out_valid_next = 1'b0;
        if (pop && head.op == OP_LAST) begin
            out_valid_next = 1'b1;
            ok_next        = (len_reg != 7'd0) && (sum_next == check_next);
            roll_next      = {att_next[0], att_next[1]};
            pitch_next     = {att_next[2], att_next[3]};
            yaw_next       = {att_next[4], att_next[5]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 8'd0;
            len_reg       <= 7'd0;
            sum_reg       <= 8'd0;
            check_reg     <= 8'd0;
            for (int i = 0; i < ATT_BYTES; i++) att_reg[i] <= 8'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            check_reg     <= check_next;
            for (int i = 0; i < ATT_BYTES; i++) att_reg[i] <= att_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg    <= ok_next;
        roll_reg  <= roll_next;
        pitch_reg <= pitch_next;
        yaw_reg   <= yaw_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, yaw_reg, pitch_reg, roll_reg, ok_reg};

endmodule
